// File: sv/plpf_pkg.sv
// Shared types, constants and helpers of the pyramid low-pass filter.
// No dependencies; used by every module of the block.
`default_nettype none
package plpf_pkg;

   localparam int MAX_RADIUS = 3;
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int NSLOTS     = 2 * MAX_RADIUS + 2;
   localparam int SLOT_BITS  = $clog2(NSLOTS);
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int DIM_BITS   = 12;
   localparam int TAP_BITS   = 3;
   localparam int SUM_BITS   = 16;
   localparam int LEAD_BITS  = 13;

   // floor(s / 81) == (s * RECIP81) >> RECIP_SHIFT for every s up to 81 * 255
   localparam logic [14:0] RECIP81     = 15'd25891;
   localparam int          RECIP_SHIFT = 21;

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef struct packed {
      logic [7:0] pix_red;
      logic [7:0] pix_green;
      logic [7:0] pix_blue;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       end_of_frame;
   } rsp_type;

   // one output pixel to be produced by the back end
   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic [1:0]          fr;    // filter radius, 0 means pass through
      logic                eof;
   } job_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] slot;
      logic [COL_BITS-1:0]  col;
      logic [23:0]          data;
   } wr_type;

   typedef struct packed {
      logic full;
      logic back_idle;
   } qstat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DRAIN,
      BK_DIV
   } back_state_type;

   // pyramid weight min(d, 2r-d) + 1
   function automatic logic [2:0] tap_weight(input logic [TAP_BITS-1:0] d,
                                             input logic [1:0] r);
      logic [TAP_BITS-1:0] two_r;
      logic [TAP_BITS-1:0] mirror;
      begin
         two_r  = {r, 1'b0};
         mirror = two_r - d;
         tap_weight = (d < mirror) ? d + 3'd1 : mirror + 3'd1;
      end
   endfunction

endpackage
`default_nettype wire

// File: sv/plpf_front.sv
// Front end: configuration registers, input/output position tracking,
// line store writes and job generation. Uses plpf_pkg.
`default_nettype none
module plpf_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire plpf_pkg::req_type         req_data,
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [11:0]               csr_wdata,
   input  wire plpf_pkg::qstat_type       qstat,
   output logic                           push,
   output plpf_pkg::job_type              push_job,
   output plpf_pkg::wr_type               wr
);

   logic [1:0]                         radius_ff, radius_in;
   logic [plpf_pkg::DIM_BITS-1:0]      width_ff, width_in;
   logic [plpf_pkg::DIM_BITS-1:0]      height_ff, height_in;
   logic [plpf_pkg::COL_BITS-1:0]      in_col_ff, in_col_in;
   logic [plpf_pkg::DIM_BITS-1:0]      in_row_ff, in_row_in;
   logic [plpf_pkg::COL_BITS-1:0]      out_col_ff, out_col_in;
   logic [plpf_pkg::ROW_BITS-1:0]      out_row_ff, out_row_in;
   logic [plpf_pkg::LEAD_BITS-1:0]     lead_ff, lead_in;
   logic                               hold_ff, hold_in;

   logic [plpf_pkg::DIM_BITS-1:0]      w_eff, h_eff;
   logic [plpf_pkg::LEAD_BITS-1:0]     delay;
   logic                               accept, write_px, emit, eof;
   logic [plpf_pkg::DIM_BITS-1:0]      col_inc, row_ocur, ocol_inc, row_next;
   logic [plpf_pkg::LEAD_BITS-1:0]     lead_next;
   logic [plpf_pkg::DIM_BITS-1:0]      r12;
   logic                               filt;

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) w_eff = 12'd1;
      else if (width_ff > 12'(plpf_pkg::MAX_WIDTH)) w_eff = 12'(plpf_pkg::MAX_WIDTH);
      h_eff = height_ff;
      if (height_ff == '0) h_eff = 12'd1;
      else if (height_ff > 12'(plpf_pkg::MAX_HEIGHT)) h_eff = 12'(plpf_pkg::MAX_HEIGHT);
   end

   assign delay     = 13'(radius_ff * w_eff) + 13'(radius_ff);
   assign req_stall = qstat.full | hold_ff;
   assign accept    = req_valid & ~req_stall;
   assign write_px  = accept & ~req_data.flush & (in_row_ff != h_eff);

   assign col_inc   = {1'b0, in_col_ff} + 12'd1;
   assign ocol_inc  = {1'b0, out_col_ff} + 12'd1;
   assign row_ocur  = {1'b0, out_row_ff};
   assign r12       = {10'b0, radius_ff};

   assign filt = (radius_ff != 2'd0) && (row_ocur >= r12) && (row_ocur + r12 < h_eff) &&
                 ({1'b0, out_col_ff} >= r12) && ({1'b0, out_col_ff} + r12 < w_eff);
   assign eof  = (row_ocur + 12'd1 == h_eff) && (ocol_inc == w_eff);

   always_comb begin
      radius_in  = radius_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lead_in    = lead_ff;
      hold_in    = hold_ff & ~(~qstat.full & qstat.back_idle);
      row_next   = in_row_ff;
      lead_next  = lead_ff;
      emit       = 1'b0;

      if (write_px) begin
         if (col_inc >= w_eff) begin
            in_col_in = '0;
            row_next  = in_row_ff + 12'd1;
         end else begin
            in_col_in = col_inc[plpf_pkg::COL_BITS-1:0];
         end
         lead_next = lead_ff + 13'd1;
      end
      in_row_in = row_next;
      lead_in   = lead_next;

      if (accept) begin
         emit = (row_next == h_eff) || (lead_next > delay);
      end

      if (emit) begin
         if (eof) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            lead_in    = '0;
            hold_in    = 1'b1;
         end else begin
            lead_in = lead_next - 13'd1;
            if (ocol_inc >= w_eff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 11'd1;
            end else begin
               out_col_in = ocol_inc[plpf_pkg::COL_BITS-1:0];
            end
         end
      end

      // a register write restarts the frame
      if (csr_we && (csr_index inside {plpf_pkg::REG_RADIUS, plpf_pkg::REG_WIDTH,
                                       plpf_pkg::REG_HEIGHT})) begin
         case (csr_index)
            plpf_pkg::REG_RADIUS: radius_in = csr_wdata[1:0];
            plpf_pkg::REG_WIDTH:  width_in  = csr_wdata;
            plpf_pkg::REG_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lead_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= 2'd1;
         width_ff   <= 12'd640;
         height_ff  <= 12'd480;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lead_ff    <= '0;
         hold_ff    <= 1'b0;
      end else begin
         radius_ff  <= radius_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lead_ff    <= lead_in;
         hold_ff    <= hold_in;
      end
   end

   assign push         = emit;
   assign push_job.row = out_row_ff;
   assign push_job.col = out_col_ff;
   assign push_job.fr  = filt ? radius_ff : 2'd0;
   assign push_job.eof = eof;

   assign wr.en   = write_px;
   assign wr.slot = in_row_ff[plpf_pkg::SLOT_BITS-1:0];
   assign wr.col  = in_col_ff;
   assign wr.data = {req_data.pix_red, req_data.pix_green, req_data.pix_blue};

endmodule
`default_nettype wire

// File: sv/plpf_queue.sv
// One-entry job queue between the front and back ends.
// Uses plpf_pkg job types.
`default_nettype none
module plpf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire plpf_pkg::job_type push_job,
   input  wire logic              pop,
   output logic                   full,
   output plpf_pkg::job_type      head
);

   logic              valid_ff, valid_in;
   plpf_pkg::job_type job_ff, job_in;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (pop) valid_in = 1'b0;
      if (push) begin
         valid_in = 1'b1;
         job_in   = push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign full = valid_ff;
   assign head = job_ff;

endmodule
`default_nettype wire

// File: sv/plpf_back.sv
// Back end: line store memory, window sequencer, weighted accumulation,
// normalization and the result register. Uses plpf_pkg.
`default_nettype none
module plpf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire plpf_pkg::wr_type  wr,
   input  wire logic              job_valid,
   input  wire plpf_pkg::job_type job,
   output logic                   pop,
   output logic                   idle,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output plpf_pkg::rsp_type      rsp_data
);

   localparam int ADDR_BITS = plpf_pkg::SLOT_BITS + plpf_pkg::COL_BITS;

   logic [23:0] mem [2**ADDR_BITS];

   plpf_pkg::back_state_type state_ff, state_in;
   plpf_pkg::job_type        job_ff, job_in;
   logic [plpf_pkg::TAP_BITS-1:0] dy_ff, dy_in, dx_ff, dx_in;
   logic [plpf_pkg::SUM_BITS-1:0] sum_r_ff, sum_g_ff, sum_b_ff;
   logic                          clr_sum;
   logic                          rd_vld_ff, rd_vld_in;
   logic [4:0]                    rd_wt_ff, rd_wt_in;
   logic [23:0]                   rd_data_ff;
   logic [ADDR_BITS-1:0]          rd_addr;
   logic [plpf_pkg::SLOT_BITS-1:0] tap_slot;
   logic [plpf_pkg::COL_BITS-1:0]  tap_col;
   logic [plpf_pkg::TAP_BITS-1:0]  two_r;
   logic                          load_out;
   logic                          rsp_valid_ff, rsp_valid_in;
   plpf_pkg::rsp_type             rsp_ff, rsp_in;

   function automatic logic [7:0] norm(input logic [plpf_pkg::SUM_BITS-1:0] s,
                                       input logic [1:0] r);
      logic [30:0] prod;
      begin
         prod = 31'(s) * 31'(plpf_pkg::RECIP81);
         case (r)
            2'd0:    norm = s[7:0];
            2'd1:    norm = s[11:4];
            2'd2:    norm = prod[plpf_pkg::RECIP_SHIFT+7:plpf_pkg::RECIP_SHIFT];
            2'd3:    norm = s[15:8];
            default: norm = s[7:0];
         endcase
      end
   endfunction

   assign two_r    = {job_ff.fr, 1'b0};
   assign tap_slot = job_ff.row[plpf_pkg::SLOT_BITS-1:0] - {1'b0, job_ff.fr} + dy_ff;
   assign tap_col  = job_ff.col - {9'b0, job_ff.fr} + {8'b0, dx_ff};
   assign rd_addr  = {tap_slot, tap_col};
   assign load_out = (state_ff == plpf_pkg::BK_DIV) & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      dy_in     = dy_ff;
      dx_in     = dx_ff;
      rd_vld_in = 1'b0;
      rd_wt_in  = 5'(plpf_pkg::tap_weight(dy_ff, job_ff.fr)) *
                  5'(plpf_pkg::tap_weight(dx_ff, job_ff.fr));
      clr_sum   = 1'b0;
      pop       = 1'b0;
      case (state_ff)
         plpf_pkg::BK_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               job_in   = job;
               dy_in    = '0;
               dx_in    = '0;
               clr_sum  = 1'b1;
               state_in = plpf_pkg::BK_RUN;
            end
         end
         plpf_pkg::BK_RUN: begin
            rd_vld_in = 1'b1;
            if (dx_ff == two_r) begin
               dx_in = '0;
               dy_in = dy_ff + 3'd1;
               if (dy_ff == two_r) state_in = plpf_pkg::BK_DRAIN;
            end else begin
               dx_in = dx_ff + 3'd1;
            end
         end
         plpf_pkg::BK_DRAIN: state_in = plpf_pkg::BK_DIV;
         plpf_pkg::BK_DIV: begin
            if (load_out) state_in = plpf_pkg::BK_IDLE;
         end
         default: state_in = plpf_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      if (load_out) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_red      = norm(sum_r_ff, job_ff.fr);
         rsp_in.out_green    = norm(sum_g_ff, job_ff.fr);
         rsp_in.out_blue     = norm(sum_b_ff, job_ff.fr);
         rsp_in.end_of_frame = job_ff.eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plpf_pkg::BK_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      dy_ff    <= dy_in;
      dx_ff    <= dx_in;
      rd_wt_ff <= rd_wt_in;
      rsp_ff   <= rsp_in;
      if (clr_sum) begin
         sum_r_ff <= '0;
         sum_g_ff <= '0;
         sum_b_ff <= '0;
      end else if (rd_vld_ff) begin
         sum_r_ff <= sum_r_ff + 16'(rd_wt_ff * rd_data_ff[23:16]);
         sum_g_ff <= sum_g_ff + 16'(rd_wt_ff * rd_data_ff[15:8]);
         sum_b_ff <= sum_b_ff + 16'(rd_wt_ff * rd_data_ff[7:0]);
      end
   end

   // line store: one write port from the front end, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) mem[{wr.slot, wr.col}] <= wr.data;
      rd_data_ff <= mem[rd_addr];
   end

   assign idle      = (state_ff == plpf_pkg::BK_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: sv/pyramid_lowpass_filter_rgb.sv
// Pyramid low-pass filter for an RGB raster stream: top level.
// Pixels enter on req_*, filtered pixels leave on rsp_* in raster order.
// A transaction on req_ carries one pixel or a flush; flushes after the last
// pixel of a frame drain the remaining radius rows plus radius pixels.
// csr_* writes radius (0), image_width (1), image_height (2) and restarts the
// frame. The user must write only while the block is idle; it is not enforced.
// Each output pixel reads its window from the line store one tap per cycle:
// the back end pops the job in BK_IDLE, reads the taps in BK_RUN, adds the
// last tap in BK_DRAIN and loads the result register in BK_DIV, raising
// rsp_valid. The single read port of the line store sets this rate. The front
// end takes a transaction while the back end works on the previous result, and
// holds req_stall after the frame's last result is queued until it is done.
// Reset restores radius 1, 640 x 480 and restarts the frame; line store
// contents are not cleared. While rsp_stall is high the result register holds
// and the back end waits, which in turn stalls req_.
// Depends on plpf_pkg, plpf_front, plpf_queue and plpf_back.
`default_nettype none
module pyramid_lowpass_filter_rgb (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire plpf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output plpf_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [11:0]       csr_wdata
);

   plpf_pkg::qstat_type qstat;
   plpf_pkg::job_type   push_job, head;
   plpf_pkg::wr_type    wr;
   logic                push, pop, full, back_idle;

   assign qstat.full      = full;
   assign qstat.back_idle = back_idle;

   plpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .qstat     (qstat),
      .push      (push),
      .push_job  (push_job),
      .wr        (wr)
   );

   plpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .head     (head)
   );

   plpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .job_valid (full),
      .job       (head),
      .pop       (pop),
      .idle      (back_idle),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench of pyramid_lowpass_filter_rgb: random RGB frames under
// varied radius and frame sizes, checked against an in-bench window filter.
// Depends on plpf_pkg and the pyramid_lowpass_filter_rgb top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   typedef struct {
      bit                 is_csr;
      logic [1:0]         idx;
      logic [11:0]        val;
      plpf_pkg::req_type  item;
   } stim_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   plpf_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   plpf_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = plpf_pkg::REG_RADIUS;
   logic [11:0]       csr_wdata = '0;

   pyramid_lowpass_filter_rgb u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [23:0] row_ring [0:plpf_pkg::NSLOTS-1][0:plpf_pkg::MAX_WIDTH-1];
   logic [1:0]  cfg_radius = 2'd1;
   logic [11:0] cfg_width  = 12'd640;
   logic [11:0] cfg_height = 12'd480;
   int          in_col = 0, in_row = 0, out_col = 0, out_row = 0;

   stim_entry_type    pending_q[$];
   plpf_pkg::rsp_type filtered_q[$];
   bit          req_taken = 1'b0;
   bit          calm = 1'b0;
   int          gap_cnt = 0, stall_cnt = 0, settle_cnt = 64;
   int          mismatches = 0, results_seen = 0, items_sent = 0, frames_queued = 0;
   int          gen_items = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int eff_dim(input logic [11:0] v);
      if (v == 0) return 1;
      return (v > plpf_pkg::MAX_WIDTH) ? plpf_pkg::MAX_WIDTH : int'(v);
   endfunction

   function automatic int pyr_weight(input int d, input int r);
      return ((d < 2 * r - d) ? d : 2 * r - d) + 1;
   endfunction

   function automatic bit filter_step(input plpf_pkg::req_type it,
                                      output plpf_pkg::rsp_type res);
      int r, w, h, total, delay, ipos, opos, den;
      int sum_r, sum_g, sum_b, wt;
      logic [23:0] px;
      r = cfg_radius;
      w = eff_dim(cfg_width);
      h = eff_dim(cfg_height);
      total = w * h;
      delay = r * w + r;
      res = '0;
      ipos = in_row * w + in_col;
      if (!it.flush && ipos < total) begin
         row_ring[in_row % plpf_pkg::NSLOTS][in_col] = {it.pix_red, it.pix_green, it.pix_blue};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         ipos++;
      end
      opos = out_row * w + out_col;
      if (ipos == total) begin
         if (opos >= total) return 0;
      end else if (ipos <= opos + delay) begin
         return 0;
      end
      if (r > 0 && out_row >= r && out_row + r < h && out_col >= r && out_col + r < w) begin
         sum_r = 0; sum_g = 0; sum_b = 0;
         den = (r + 1) ** 4;
         for (int dy = 0; dy <= 2 * r; dy++)
            for (int dx = 0; dx <= 2 * r; dx++) begin
               px = row_ring[(out_row - r + dy) % plpf_pkg::NSLOTS][out_col - r + dx];
               wt = pyr_weight(dy, r) * pyr_weight(dx, r);
               sum_r += wt * px[23:16];
               sum_g += wt * px[15:8];
               sum_b += wt * px[7:0];
            end
         res.out_red = 8'(sum_r / den);
         res.out_green = 8'(sum_g / den);
         res.out_blue = 8'(sum_b / den);
      end else begin
         px = row_ring[out_row % plpf_pkg::NSLOTS][out_col];
         {res.out_red, res.out_green, res.out_blue} = px;
      end
      res.end_of_frame = (opos + 1 == total);
      if (opos + 1 == total) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1;
   endfunction

   // stimulus builders
   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_cfg(input int r, input int wreg, input int hreg);
      stim_entry_type e;
      e.is_csr = 1; e.item = '0;
      e.idx = plpf_pkg::REG_RADIUS; e.val = 12'(r);    pending_q.push_back(e);
      e.idx = plpf_pkg::REG_WIDTH;  e.val = 12'(wreg); pending_q.push_back(e);
      e.idx = plpf_pkg::REG_HEIGHT; e.val = 12'(hreg); pending_q.push_back(e);
   endtask

   // one frame of pixels, optional stray flushes, then enough drain items
   task automatic push_frame(input int r, input int wreg, input int hreg,
                             input int fill, input bit noisy);
      stim_entry_type e;
      int w, h, total, drains;
      w = eff_dim(12'(wreg));
      h = eff_dim(12'(hreg));
      total = w * h;
      drains = (r * w + r < total - 1) ? r * w + r : total - 1;
      e.is_csr = 0; e.idx = plpf_pkg::REG_RADIUS; e.val = '0;
      for (int k = 0; k < total; k++) begin
         if (noisy && $urandom_range(0, 15) == 0) begin
            e.item = '{8'($urandom), 8'($urandom), 8'($urandom), 1'b1};
            pending_q.push_back(e);
         end
         if (fill < 0)
            e.item = '{rand_chan(), rand_chan(), rand_chan(), 1'b0};
         else
            e.item = '{8'(fill), 8'(fill), 8'(fill), 1'b0};
         pending_q.push_back(e);
      end
      // drains: flush or a pixel past the frame, both release one result
      for (int k = 0; k < drains; k++) begin
         e.item = '{8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)};
         pending_q.push_back(e);
      end
      if (noisy && $urandom_range(0, 3) == 0) begin
         e.item = '{8'($urandom), 8'($urandom), 8'($urandom), 1'b1};
         pending_q.push_back(e);
      end
      gen_items += total + drains;
      frames_queued++;
   endtask

   // driver
   always @(negedge clock) begin
      bit                nv, cwe;
      plpf_pkg::req_type nd;
      logic [1:0]        ci;
      logic [11:0]       cd;
      stim_entry_type    e;
      nv = 0; cwe = 0; nd = req_data; ci = csr_index; cd = csr_wdata;
      if (!reset && !(req_valid && !req_taken)) begin
         calm = (pending_q.size() < 150);
         if (gap_cnt > 0) begin
            gap_cnt--;
         end else if (pending_q.size() > 0) begin
            e = pending_q[0];
            if (e.is_csr) begin
               if (filtered_q.size() != 0) begin
                  settle_cnt = 64;
               end else if (settle_cnt > 0) begin
                  settle_cnt--;
               end else begin
                  cwe = 1; ci = e.idx; cd = e.val;
                  void'(pending_q.pop_front());
                  settle_cnt = (pending_q.size() > 0 && pending_q[0].is_csr) ? 0 : 64;
               end
            end else begin
               nv = 1; nd = e.item;
               void'(pending_q.pop_front());
               if (!calm && $urandom_range(0, 9) == 0) gap_cnt = $urandom_range(1, 16);
            end
         end
         req_valid <= nv;
         req_data  <= nd;
         csr_we    <= cwe;
         csr_index <= ci;
         csr_wdata <= cd;
      end
      if (!reset) begin
         if (stall_cnt > 0) begin
            stall_cnt--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_cnt = $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      plpf_pkg::rsp_type exp_px, got_px;
      req_taken = 0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (filtered_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected output transaction %p", rsp_data);
            end else begin
               exp_px = filtered_q.pop_front();
               if (rsp_data.out_red !== exp_px.out_red ||
                   rsp_data.out_green !== exp_px.out_green ||
                   rsp_data.out_blue !== exp_px.out_blue ||
                   rsp_data.end_of_frame !== exp_px.end_of_frame) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at result %0d: expected %p, got %p",
                              results_seen, exp_px, rsp_data);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               plpf_pkg::REG_RADIUS: cfg_radius = csr_wdata[1:0];
               plpf_pkg::REG_WIDTH:  cfg_width  = csr_wdata;
               plpf_pkg::REG_HEIGHT: cfg_height = csr_wdata;
               default: ;
            endcase
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end
         if (req_valid && !req_stall) begin
            req_taken = 1;
            items_sent++;
            if (filter_step(req_data, got_px)) filtered_q.push_back(got_px);
         end
      end
   end

   initial begin
      int r, w, h;
      // directed: every radius, extreme values, frames smaller than the window,
      // zero dimensions
      push_cfg(0, 3, 2);    push_frame(0, 3, 2, -1, 0);
      push_cfg(1, 3, 3);    push_frame(1, 3, 3, 255, 0);
      push_cfg(2, 5, 5);    push_frame(2, 5, 5, -1, 1);
      push_cfg(3, 7, 7);    push_frame(3, 7, 7, 255, 0);
      push_cfg(3, 4, 4);    push_frame(3, 4, 4, 0, 0);
      push_cfg(1, 0, 0);    push_frame(1, 0, 0, -1, 0);
      while (gen_items < 1100) begin
         r = $urandom_range(0, 3);
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 10);
         push_cfg(r, w, h);
         repeat ($urandom_range(1, 3)) push_frame(r, w, h, -1, 1);
      end
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      forever begin
         @(posedge clock);
         if (pending_q.size() == 0 && !req_valid && filtered_q.size() == 0) break;
      end
      repeat (200) @(posedge clock);
      $display("%0d transactions in, %0d filtered pixels out over %0d frames",
               items_sent, results_seen, frames_queued);
      $display("radius 0..3, frames from 1x1 up to 12 x 10; %0d mismatches",
               mismatches + filtered_q.size());
      if (mismatches == 0 && filtered_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #8ms;
      $display("timeout: %0d results still expected", filtered_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire
